// ----- sv/crcae_pkg.sv -----
// shared constants, types and table helper for the crc64 append engine
`default_nettype none
package crcae_pkg;

    // crc geometry
    localparam int CRC_WIDTH   = 64;
    localparam int BYTE_W      = 8;
    localparam int CRC_BYTES   = CRC_WIDTH / BYTE_W;
    localparam int IDX_W       = $clog2(CRC_BYTES);

    // polynomial after reset
    localparam logic [CRC_WIDTH-1:0] POLY_RESET = 64'h0000_0000_0000_001B;

    // queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef logic [CRC_WIDTH-1:0] t_crc;

    // one table entry per index bit; the byte table is the xor of these
    typedef t_crc [BYTE_W-1:0] t_basis;

    // push side of the queue
    typedef struct packed {
        logic push;
        t_crc crc;
    } t_q_wr;

    // status of the queue
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    // table entry for a single set bit j of the index, for all j
    function automatic t_basis basis_from_poly(input t_crc poly);
        t_basis b;
        t_crc   v;
        logic   top;
        for (int j = 0; j < BYTE_W; j++) begin
            v = t_crc'(1) << (CRC_WIDTH - BYTE_W + j);
            for (int k = 0; k < BYTE_W; k++) begin
                top = v[CRC_WIDTH-1];
                v   = v << 1;
                if (top) begin
                    v = v ^ poly;
                end
            end
            b[j] = v;
        end
        return b;
    endfunction

endpackage
`default_nettype wire

// ----- sv/crcae_front.sv -----
// front part: polynomial table basis, byte-wise crc update, packet close
`default_nettype none
module crcae_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [crcae_pkg::CRC_WIDTH-1:0] i_cfg_wdata,
    input  wire logic                         i_accept,
    input  wire logic [crcae_pkg::BYTE_W-1:0] i_data_byte,
    input  wire logic                         i_end_of_packet,
    output crcae_pkg::t_q_wr                  o_q_wr
);
    import crcae_pkg::*;

    t_basis r_basis;
    t_crc   r_crc;
    t_crc   n_crc;
    t_crc   w_entry;
    logic [BYTE_W-1:0] w_idx;

    // table basis follows the polynomial on every write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_basis <= basis_from_poly(POLY_RESET);
        end else if (i_cfg_we) begin
            r_basis <= basis_from_poly(i_cfg_wdata);
        end
    end

    // table lookup as xor of the basis entries picked by the index bits
    always_comb begin
        w_idx   = r_crc[CRC_WIDTH-1 -: BYTE_W] ^ i_data_byte;
        w_entry = '0;
        for (int j = 0; j < BYTE_W; j++) begin
            if (w_idx[j]) begin
                w_entry = w_entry ^ r_basis[j];
            end
        end
        n_crc = (r_crc << BYTE_W) ^ w_entry;
    end

    // running crc, cleared after the last byte of a packet
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= '0;
        end else if (i_accept) begin
            r_crc <= i_end_of_packet ? '0 : n_crc;
        end
    end

    // finished crc goes to the queue
    assign o_q_wr.push = i_accept && i_end_of_packet;
    assign o_q_wr.crc  = n_crc;

endmodule
`default_nettype wire

// ----- sv/crcae_queue.sv -----
// short queue of finished crc values between front and back
`default_nettype none
module crcae_queue (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire crcae_pkg::t_q_wr i_q_wr,
    input  wire logic     i_pop,
    output crcae_pkg::t_q_stat o_stat,
    output crcae_pkg::t_crc    o_head
);
    import crcae_pkg::*;

    t_crc r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic w_push;
    logic w_pop;

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign w_push = i_q_wr.push && !o_stat.full;
    assign w_pop  = i_pop && !o_stat.empty;

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_q_wr.crc;
        end
    end

    assign o_head = r_mem[r_rd_ptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- sv/crcae_back.sv -----
// back part: sends the eight bytes of each queued crc, most significant first
`default_nettype none
module crcae_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_q_empty,
    input  wire crcae_pkg::t_crc               i_head,
    input  wire logic                          i_pop,
    output logic                               o_q_pop,
    output logic [crcae_pkg::BYTE_W-1:0]       o_crc_byte,
    output logic [crcae_pkg::IDX_W-1:0]        o_crc_byte_index,
    output logic                               o_crc_last
);
    import crcae_pkg::*;

    logic [IDX_W-1:0] r_idx;
    logic             w_take;
    logic             w_last;

    assign w_take = i_pop && !i_q_empty;
    assign w_last = (r_idx == IDX_W'(CRC_BYTES - 1));

    // byte position within the current crc
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (w_take) begin
            r_idx <= w_last ? '0 : r_idx + 1'b1;
        end
    end

    // byte select, index 0 is the top byte
    assign o_crc_byte       = i_head[{~r_idx, 3'b000} +: BYTE_W];
    assign o_crc_byte_index = r_idx;
    assign o_crc_last       = w_last;
    assign o_q_pop          = w_take && w_last;

endmodule
`default_nettype wire

// ----- sv/crc64_append_engine_core.sv -----
// top level of the crc64 append engine
//
// channel   direction  handshake            payload
// input     in         push / full          i_data_byte, i_end_of_packet
// result    out        empty / pop          o_crc_byte, o_crc_byte_index, o_crc_last
// config    in         i_cfg_we             i_cfg_wdata (polynomial)
//
// one byte is taken per cycle while full is low; the crc update goes through the
// xor of eight table basis entries held in registers
// a last byte queues its crc (two entries); each crc leaves as eight results,
// one per cycle while pop is high
// full rises only when both queue entries wait, so the result side sets the
// sustained rate for short packets
// synchronous reset clears the crc, the queue and the byte position and
// restores the reset polynomial
`default_nettype none
module crc64_append_engine_core (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [crcae_pkg::CRC_WIDTH-1:0]  i_cfg_wdata,
    input  wire logic                             push,
    output logic                                  full,
    input  wire logic [crcae_pkg::BYTE_W-1:0]     i_data_byte,
    input  wire logic                             i_end_of_packet,
    output logic                                  empty,
    input  wire logic                             pop,
    output logic [crcae_pkg::BYTE_W-1:0]          o_crc_byte,
    output logic [crcae_pkg::IDX_W-1:0]           o_crc_byte_index,
    output logic                                  o_crc_last
);
    import crcae_pkg::*;

    t_q_wr   w_q_wr;
    t_q_stat w_stat;
    t_crc    w_head;
    logic    w_q_pop;
    logic    w_accept;

    assign w_accept = push && !w_stat.full;
    assign full     = w_stat.full;
    assign empty    = w_stat.empty;

    // byte intake and crc update
    crcae_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_accept        (w_accept),
        .i_data_byte     (i_data_byte),
        .i_end_of_packet (i_end_of_packet),
        .o_q_wr          (w_q_wr)
    );

    // finished crc values
    crcae_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q_wr  (w_q_wr),
        .i_pop   (w_q_pop),
        .o_stat  (w_stat),
        .o_head  (w_head)
    );

    // byte serializer
    crcae_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_empty        (w_stat.empty),
        .i_head           (w_head),
        .i_pop            (pop),
        .o_q_pop          (w_q_pop),
        .o_crc_byte       (o_crc_byte),
        .o_crc_byte_index (o_crc_byte_index),
        .o_crc_last       (o_crc_last)
    );

endmodule
`default_nettype wire
